// ----- rtl/rmsf_pkg.sv -----
// Shared types and codes for the robot mode safety FSM.
// Used by the channel interfaces, the core and its checker; no dependencies.
package rmsf_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    KIND_SWITCH = 2'd0,
    KIND_ESTOP  = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    MD_IDLE    = 3'd0,
    MD_MANUAL  = 3'd1,
    MD_TELEOP  = 3'd2,
    MD_AUTO    = 3'd3,
    MD_MAPPING = 3'd4,
    MD_ESTOP   = 3'd5,
    MD_UNK6    = 3'd6,
    MD_UNK7    = 3'd7
  } mode_t;

  typedef enum logic [3:0] {
    RSN_OK            = 4'd0,
    RSN_ALREADY       = 4'd1,
    RSN_ESTOP_IDLE    = 4'd2,
    RSN_USE_ESTOP     = 4'd3,
    RSN_MANUAL_SRC    = 4'd4,
    RSN_TELEOP_SRC    = 4'd5,
    RSN_NO_LEASE      = 4'd6,
    RSN_AUTO_SRC      = 4'd7,
    RSN_NO_XFORM      = 4'd8,
    RSN_NO_LOC        = 4'd9,
    RSN_MAPPING_SRC   = 4'd10,
    RSN_UNKNOWN       = 4'd11,
    RSN_NOT_ESTOP     = 4'd12,
    RSN_TILT          = 4'd13,
    RSN_FENCE         = 4'd14,
    RSN_SPARE         = 4'd15
  } reason_t;

  typedef enum logic [1:0] {
    STOP_RELEASE = 2'd0,
    STOP_ZERO    = 2'd1,
    STOP_FULL    = 2'd2,
    STOP_SPARE   = 2'd3
  } stop_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEASE  = 3'd0,
    CFG_XFORM  = 3'd1,
    CFG_LOC    = 3'd2,
    CFG_TILT   = 3'd3,
    CFG_FENCE  = 3'd4,
    CFG_RSV5   = 3'd5,
    CFG_RSV6   = 3'd6,
    CFG_RSV7   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic       accepted;
    logic [3:0] reason_code;
    logic [2:0] mode_now;
    logic       stop_valid;
    logic [1:0] stop_level;
  } res_t;

endpackage

// ----- rtl/rmsf_ifs.sv -----
// Valid/ready channel interfaces for the robot mode safety FSM:
// request input, result output and configuration write. Depends on rmsf_pkg.
interface rmsf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [2:0] target_mode;
  logic       lease_ok;
  logic       transform_ok;
  logic       localization_ok;
  logic       tilt_ok;
  logic       fence_ok;

  modport source (output valid, mode, target_mode, lease_ok, transform_ok,
                  localization_ok, tilt_ok, fence_ok, input ready);
  modport sink   (input valid, mode, target_mode, lease_ok, transform_ok,
                  localization_ok, tilt_ok, fence_ok, output ready);
  modport mon    (input valid, ready, mode, target_mode, lease_ok, transform_ok,
                  localization_ok, tilt_ok, fence_ok);
endinterface

interface rmsf_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [3:0] reason_code;
  logic [2:0] mode_now;
  logic       stop_valid;
  logic [1:0] stop_level;

  modport source (output valid, accepted, reason_code, mode_now, stop_valid,
                  stop_level, input ready);
  modport sink   (input valid, accepted, reason_code, mode_now, stop_valid,
                  stop_level, output ready);
  modport mon    (input valid, ready, accepted, reason_code, mode_now,
                  stop_valid, stop_level);
endinterface

interface rmsf_cfg_if import rmsf_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic                 data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
  modport mon    (input valid, ready, index, data);
endinterface

// ----- rtl/robot_mode_safety_fsm_core.sv -----
// Robot operating-mode safety state machine: guarded mode switching,
// emergency stop and clear, with a two-entry result queue.
// Depends on rmsf_pkg and the channel interfaces in rmsf_ifs.sv.
//
//   channel  | dir | payload                                         | accept
//   ---------+-----+-------------------------------------------------+-------------
//   in_ch    | in  | mode, target_mode, lease/xform/loc/tilt/fence ok | valid & ready
//   out_ch   | out | accepted, reason_code, mode_now, stop_valid/lvl | valid & ready
//   cfg_ch   | in  | index (3 bits), data (1 bit)                    | valid & ready
//
// One request per cycle while in_ch.ready is high; its result is registered on acceptance.
// The guard check is combinational and the mode register updates on acceptance.
// A second result is held in a skid entry while the output stalls; in_ch.ready
// drops only when both entries are full. cfg_ch.ready is always high.
// Reset (rst_n low, synchronous) sets idle mode, all checks on, queue empty.
module robot_mode_safety_fsm_core import rmsf_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  rmsf_in_if.sink   in_ch,
  rmsf_out_if.source out_ch,
  rmsf_cfg_if.sink  cfg_ch
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_MANUAL  = 6'b000010,
    ST_TELEOP  = 6'b000100,
    ST_AUTO    = 6'b001000,
    ST_MAPPING = 6'b010000,
    ST_ESTOP   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic lease_chk_r, xform_chk_r, loc_chk_r, tilt_chk_r, fence_chk_r;
  logic out_valid_r, skid_valid_r;
  res_t out_r, skid_r;
  res_t res;
  mode_t cur_mode, tgt_mode, res_mode;
  kind_t kind;
  reason_t guard;
  logic push, pop;

  function automatic mode_t state_to_mode(state_t s);
    mode_t m;
    case (s)
      ST_IDLE:    m = MD_IDLE;
      ST_MANUAL:  m = MD_MANUAL;
      ST_TELEOP:  m = MD_TELEOP;
      ST_AUTO:    m = MD_AUTO;
      ST_MAPPING: m = MD_MAPPING;
      ST_ESTOP:   m = MD_ESTOP;
      default:    m = MD_IDLE;
    endcase
    return m;
  endfunction

  function automatic state_t mode_to_state(mode_t m);
    state_t s;
    case (m)
      MD_MANUAL:  s = ST_MANUAL;
      MD_TELEOP:  s = ST_TELEOP;
      MD_AUTO:    s = ST_AUTO;
      MD_MAPPING: s = ST_MAPPING;
      MD_ESTOP:   s = ST_ESTOP;
      default:    s = ST_IDLE;
    endcase
    return s;
  endfunction

  assign cur_mode = state_to_mode(state_r);
  assign tgt_mode = mode_t'(in_ch.target_mode);
  assign kind     = kind_t'(in_ch.mode);

  // Transition table guard for a switch to a different mode
  always_comb begin
    guard = RSN_OK;
    if (cur_mode == MD_ESTOP && tgt_mode != MD_IDLE) begin
      guard = RSN_ESTOP_IDLE;
    end else begin
      case (tgt_mode)
        MD_IDLE:    guard = RSN_OK;
        MD_MANUAL:  guard = (cur_mode != MD_IDLE) ? RSN_MANUAL_SRC : RSN_OK;
        MD_TELEOP: begin
          if (cur_mode != MD_IDLE && cur_mode != MD_AUTO) guard = RSN_TELEOP_SRC;
          else if (lease_chk_r && !in_ch.lease_ok)        guard = RSN_NO_LEASE;
        end
        MD_AUTO: begin
          if (cur_mode != MD_IDLE && cur_mode != MD_TELEOP) guard = RSN_AUTO_SRC;
          else if (xform_chk_r && !in_ch.transform_ok)      guard = RSN_NO_XFORM;
          else if (loc_chk_r && !in_ch.localization_ok)     guard = RSN_NO_LOC;
        end
        MD_MAPPING: guard = (cur_mode != MD_IDLE) ? RSN_MAPPING_SRC : RSN_OK;
        MD_ESTOP:   guard = RSN_USE_ESTOP;
        default:    guard = RSN_UNKNOWN;
      endcase
    end
  end

  always_comb begin
    res.accepted    = 1'b0;
    res.reason_code = RSN_UNKNOWN;
    res.stop_valid  = 1'b0;
    res.stop_level  = STOP_RELEASE;
    res_mode        = cur_mode;
    case (kind)
      KIND_SWITCH: begin
        if (tgt_mode == cur_mode) begin
          res.accepted    = 1'b1;
          res.reason_code = RSN_ALREADY;
        end else begin
          res.reason_code = guard;
          if (guard == RSN_OK) begin
            res.accepted   = 1'b1;
            res.stop_valid = 1'b1;
            // entering autonomous releases the follower; other leave and enter stops merge into one zero-speed stop
            res.stop_level = (tgt_mode == MD_AUTO) ? STOP_RELEASE : STOP_ZERO;
            res_mode       = tgt_mode;
          end
        end
      end
      KIND_ESTOP: begin
        res.accepted    = 1'b1;
        res.reason_code = RSN_OK;
        res.stop_valid  = 1'b1;
        res.stop_level  = STOP_FULL;
        res_mode        = MD_ESTOP;
      end
      KIND_CLEAR: begin
        if (cur_mode != MD_ESTOP)               res.reason_code = RSN_NOT_ESTOP;
        else if (tilt_chk_r && !in_ch.tilt_ok)   res.reason_code = RSN_TILT;
        else if (fence_chk_r && !in_ch.fence_ok) res.reason_code = RSN_FENCE;
        else begin
          res.accepted    = 1'b1;
          res.reason_code = RSN_OK;
          res_mode        = MD_IDLE;
        end
      end
      default: ;
    endcase
    res.mode_now = res_mode;
  end

  assign in_ch.ready  = !skid_valid_r;
  assign cfg_ch.ready = 1'b1;
  assign push = in_ch.valid && in_ch.ready;
  assign pop  = out_valid_r && out_ch.ready;

  assign state_nxt = push ? mode_to_state(res_mode) : state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      lease_chk_r  <= 1'b1;
      xform_chk_r  <= 1'b1;
      loc_chk_r    <= 1'b1;
      tilt_chk_r   <= 1'b1;
      fence_chk_r  <= 1'b1;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        case (cfg_idx_t'(cfg_ch.index))
          CFG_LEASE: lease_chk_r <= cfg_ch.data;
          CFG_XFORM: xform_chk_r <= cfg_ch.data;
          CFG_LOC:   loc_chk_r   <= cfg_ch.data;
          CFG_TILT:  tilt_chk_r  <= cfg_ch.data;
          CFG_FENCE: fence_chk_r <= cfg_ch.data;
          default: ;
        endcase
      end
      if (skid_valid_r) begin
        // advance the skid entry once the head item leaves
        if (pop) skid_valid_r <= 1'b0;
      end else if (push && out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else if (pop && !push) begin
        out_valid_r <= 1'b0;
      end else if (push) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) out_r <= skid_r;
    end else if (push) begin
      if (out_valid_r && !pop) skid_r <= res;
      else                     out_r  <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.accepted    = out_r.accepted;
  assign out_ch.reason_code = out_r.reason_code;
  assign out_ch.mode_now    = out_r.mode_now;
  assign out_ch.stop_valid  = out_r.stop_valid;
  assign out_ch.stop_level  = out_r.stop_level;

endmodule

// ----- rtl/rmsf_checker.sv -----
// Port-level checker for robot_mode_safety_fsm_core, bound to the top level.
// Depends on rmsf_pkg; watches the result channel signals of the top level.
module rmsf_checker import rmsf_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_accepted,
  input logic [3:0] out_reason_code,
  input logic [2:0] out_mode_now,
  input logic       out_stop_valid,
  input logic [1:0] out_stop_level
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_reject_no_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> !out_stop_valid && out_stop_level == STOP_RELEASE)
    else $error("stop command on a rejected request");

  a_full_stop_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stop_valid && out_stop_level == STOP_FULL
      |-> out_mode_now == MD_ESTOP && out_reason_code == RSN_OK)
    else $error("full stop without estop mode");

  a_release_auto: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stop_valid && out_stop_level == STOP_RELEASE
      |-> out_mode_now == MD_AUTO)
    else $error("follower released outside autonomous mode");

endmodule

bind robot_mode_safety_fsm_core rmsf_checker u_rmsf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_accepted    (out_ch.accepted),
  .out_reason_code (out_ch.reason_code),
  .out_mode_now    (out_ch.mode_now),
  .out_stop_valid  (out_ch.stop_valid),
  .out_stop_level  (out_ch.stop_level)
);

// ----- tb/tb.sv -----
// Self-checking bench for robot_mode_safety_fsm_core: a directed table, then random
// request streams under several guard-check settings and handshake pressures.
// Depends on rmsf_pkg and the channel interfaces in rmsf_ifs.sv.
module tb;
  import rmsf_pkg::*;

  typedef struct packed {
    kind_t kind;
    mode_t target;
    logic  lease;
    logic  xform;
    logic  loc;
    logic  tilt;
    logic  fence;
  } req_t;

  typedef struct packed {
    req_t rq;
    logic typed;
    res_t res;
  } row_t;

  localparam int STALL_LIMIT  = 2000;
  localparam int N_PHASES     = 6;
  localparam int PHASE_ITEMS  = 258;

  // Opening sequence from reset with every guard check on.
  localparam row_t DIR_ROWS [26] = '{
    '{'{KIND_SWITCH, MD_IDLE, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{1'b1, RSN_ALREADY, MD_IDLE, 1'b0, STOP_RELEASE}},
    '{'{KIND_SWITCH, MD_MANUAL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{KIND_SWITCH, MD_TELEOP, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{1'b0, RSN_TELEOP_SRC, MD_MANUAL, 1'b0, STOP_RELEASE}},
    '{'{KIND_SWITCH, MD_MAPPING, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{1'b0, RSN_MAPPING_SRC, MD_MANUAL, 1'b0, STOP_RELEASE}},
    '{'{KIND_SWITCH, MD_AUTO, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{1'b0, RSN_AUTO_SRC, MD_MANUAL, 1'b0, STOP_RELEASE}},
    '{'{KIND_SWITCH, MD_ESTOP, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{1'b0, RSN_USE_ESTOP, MD_MANUAL, 1'b0, STOP_RELEASE}},
    '{'{KIND_SWITCH, MD_UNK6, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{1'b0, RSN_UNKNOWN, MD_MANUAL, 1'b0, STOP_RELEASE}},
    '{'{KIND_SWITCH, MD_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{KIND_SWITCH, MD_TELEOP, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{1'b0, RSN_NO_LEASE, MD_IDLE, 1'b0, STOP_RELEASE}},
    '{'{KIND_SWITCH, MD_TELEOP, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
    '{'{KIND_SWITCH, MD_MANUAL, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{1'b0, RSN_MANUAL_SRC, MD_TELEOP, 1'b0, STOP_RELEASE}},
    '{'{KIND_SWITCH, MD_AUTO, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{1'b0, RSN_NO_XFORM, MD_TELEOP, 1'b0, STOP_RELEASE}},
    '{'{KIND_SWITCH, MD_AUTO, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1}, 1'b1,
      '{1'b0, RSN_NO_LOC, MD_TELEOP, 1'b0, STOP_RELEASE}},
    '{'{KIND_SWITCH, MD_AUTO, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
    '{'{KIND_SWITCH, MD_TELEOP, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
    '{'{KIND_NONE, MD_UNK7, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{1'b0, RSN_UNKNOWN, MD_TELEOP, 1'b0, STOP_RELEASE}},
    '{'{KIND_CLEAR, MD_IDLE, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{1'b0, RSN_NOT_ESTOP, MD_TELEOP, 1'b0, STOP_RELEASE}},
    '{'{KIND_ESTOP, MD_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{1'b1, RSN_OK, MD_ESTOP, 1'b1, STOP_FULL}},
    '{'{KIND_ESTOP, MD_UNK7, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{1'b1, RSN_OK, MD_ESTOP, 1'b1, STOP_FULL}},
    '{'{KIND_SWITCH, MD_MANUAL, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{1'b0, RSN_ESTOP_IDLE, MD_ESTOP, 1'b0, STOP_RELEASE}},
    '{'{KIND_SWITCH, MD_ESTOP, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{1'b1, RSN_ALREADY, MD_ESTOP, 1'b0, STOP_RELEASE}},
    '{'{KIND_CLEAR, MD_IDLE, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1}, 1'b1,
      '{1'b0, RSN_TILT, MD_ESTOP, 1'b0, STOP_RELEASE}},
    '{'{KIND_CLEAR, MD_IDLE, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b1,
      '{1'b0, RSN_FENCE, MD_ESTOP, 1'b0, STOP_RELEASE}},
    '{'{KIND_CLEAR, MD_IDLE, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
    '{'{KIND_ESTOP, MD_IDLE, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{1'b1, RSN_OK, MD_ESTOP, 1'b1, STOP_FULL}},
    '{'{KIND_SWITCH, MD_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  rmsf_in_if  in_ch ();
  rmsf_out_if out_ch ();
  rmsf_cfg_if cfg_ch ();

  robot_mode_safety_fsm_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Mirror of the block's state and guard-check registers.
  mode_t      cur_mode;
  logic [4:0] chk_on;

  res_t mode_results_q [$];
  int   send_idle_pct;
  int   recv_stall_pct;
  int   n_requests;
  int   n_results;
  int   n_errs;
  int   stall_cycles;
  res_t got_res;
  res_t want_res;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("tb: mismatch at %0t: %s", $realtime, what);
    n_errs++;
  endtask

  function automatic logic coin(input int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic reason_t guard_reason(input mode_t from, input mode_t to, input req_t rq);
    if (from == MD_ESTOP && to != MD_IDLE) return RSN_ESTOP_IDLE;
    if (to == MD_ESTOP) return RSN_USE_ESTOP;
    case (to)
      MD_IDLE: return RSN_OK;
      MD_MANUAL: return (from != MD_IDLE) ? RSN_MANUAL_SRC : RSN_OK;
      MD_TELEOP: begin
        if (from != MD_IDLE && from != MD_AUTO) return RSN_TELEOP_SRC;
        if (chk_on[CFG_LEASE] && !rq.lease) return RSN_NO_LEASE;
        return RSN_OK;
      end
      MD_AUTO: begin
        if (from != MD_IDLE && from != MD_TELEOP) return RSN_AUTO_SRC;
        if (chk_on[CFG_XFORM] && !rq.xform) return RSN_NO_XFORM;
        if (chk_on[CFG_LOC] && !rq.loc) return RSN_NO_LOC;
        return RSN_OK;
      end
      MD_MAPPING: return (from != MD_IDLE) ? RSN_MAPPING_SRC : RSN_OK;
      default: return RSN_UNKNOWN;
    endcase
  endfunction

  // Work out the result of one request and advance the mirrored mode.
  function automatic res_t predict_mode_step(input req_t rq);
    res_t    r;
    reason_t why;
    r = '0;
    r.reason_code = RSN_UNKNOWN;
    case (rq.kind)
      KIND_SWITCH: begin
        if (rq.target == cur_mode) begin
          r.accepted    = 1'b1;
          r.reason_code = RSN_ALREADY;
        end else begin
          why = guard_reason(cur_mode, rq.target, rq);
          r.reason_code = why;
          if (why == RSN_OK) begin
            r.accepted   = 1'b1;
            r.stop_valid = 1'b1;
            // entering autonomous releases the follower; the rest merge into one zero-speed stop
            r.stop_level = (rq.target == MD_AUTO) ? STOP_RELEASE : STOP_ZERO;
            cur_mode     = rq.target;
          end
        end
      end
      KIND_ESTOP: begin
        r.accepted    = 1'b1;
        r.reason_code = RSN_OK;
        r.stop_valid  = 1'b1;
        r.stop_level  = STOP_FULL;
        cur_mode      = MD_ESTOP;
      end
      KIND_CLEAR: begin
        if (cur_mode != MD_ESTOP) r.reason_code = RSN_NOT_ESTOP;
        else if (chk_on[CFG_TILT] && !rq.tilt) r.reason_code = RSN_TILT;
        else if (chk_on[CFG_FENCE] && !rq.fence) r.reason_code = RSN_FENCE;
        else begin
          r.accepted    = 1'b1;
          r.reason_code = RSN_OK;
          cur_mode      = MD_IDLE;
        end
      end
      default: ;
    endcase
    r.mode_now = cur_mode;
    return r;
  endfunction

  // Mostly legal next steps from the current mode, the rest noise.
  function automatic req_t draw_request();
    req_t rq;
    int   roll;
    roll     = $urandom_range(0, 99);
    rq.lease = coin(85);
    rq.xform = coin(85);
    rq.loc   = coin(85);
    rq.tilt  = coin(85);
    rq.fence = coin(85);
    rq.kind  = KIND_SWITCH;
    rq.target = MD_IDLE;
    if (roll < 70) begin
      case (cur_mode)
        MD_IDLE: rq.target = mode_t'(3'($urandom_range(1, 4)));
        MD_TELEOP: rq.target = coin(60) ? MD_AUTO : MD_IDLE;
        MD_AUTO: rq.target = coin(60) ? MD_TELEOP : MD_IDLE;
        MD_ESTOP: begin
          if (coin(75)) begin
            rq.kind   = KIND_CLEAR;
            rq.target = mode_t'(3'($urandom_range(0, 7)));
          end
        end
        default: rq.target = MD_IDLE;
      endcase
      if (roll < 9) rq.kind = KIND_ESTOP;
    end else begin
      rq.kind   = kind_t'(2'($urandom_range(0, 3)));
      rq.target = mode_t'(3'($urandom_range(0, 7)));
      {rq.lease, rq.xform, rq.loc, rq.tilt, rq.fence} = 5'($urandom_range(0, 31));
    end
    return rq;
  endfunction

  // Present one item, hold it until taken, then queue its expected result.
  task automatic issue_request(input req_t rq, input logic typed, input res_t typed_res);
    res_t pred;
    while (coin(send_idle_pct)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.mode            <= rq.kind;
    in_ch.target_mode     <= rq.target;
    in_ch.lease_ok        <= rq.lease;
    in_ch.transform_ok    <= rq.xform;
    in_ch.localization_ok <= rq.loc;
    in_ch.tilt_ok         <= rq.tilt;
    in_ch.fence_ok        <= rq.fence;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = predict_mode_step(rq);
    mode_results_q.push_back(typed ? typed_res : pred);
    n_requests++;
  endtask

  // Write all five guard checks; optionally poke the spare indexes too.
  task automatic load_checks(input logic [4:0] bits, input bit poke_spare);
    int last;
    last = poke_spare ? 7 : 4;
    for (int k = 0; k <= last; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= cfg_idx_t'(3'(k));
      cfg_ch.data  <= (k <= 4) ? bits[k] : 1'b1;
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      if (k <= 4) chk_on[k] = bits[k];
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Result side: check every item taken, then pick the next stall.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got_res = {out_ch.accepted, out_ch.reason_code, out_ch.mode_now,
                   out_ch.stop_valid, out_ch.stop_level};
        n_results++;
        if (mode_results_q.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing pending", got_res));
        end else begin
          want_res = mode_results_q.pop_front();
          if (got_res.accepted !== want_res.accepted)
            report_mismatch($sformatf("accepted %b, want %b",
                                      got_res.accepted, want_res.accepted));
          if (got_res.reason_code !== want_res.reason_code)
            report_mismatch($sformatf("reason_code %0d, want %0d",
                                      got_res.reason_code, want_res.reason_code));
          if (got_res.mode_now !== want_res.mode_now)
            report_mismatch($sformatf("mode_now %0d, want %0d",
                                      got_res.mode_now, want_res.mode_now));
          if (got_res.stop_valid !== want_res.stop_valid)
            report_mismatch($sformatf("stop_valid %b, want %b",
                                      got_res.stop_valid, want_res.stop_valid));
          if (got_res.stop_level !== want_res.stop_level)
            report_mismatch($sformatf("stop_level %0d, want %0d",
                                      got_res.stop_level, want_res.stop_level));
        end
      end
      out_ch.ready <= !coin(recv_stall_pct);
    end
  end

  // Drop out if no channel moves anything for too long.
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("tb: no handshake for %0d cycles", STALL_LIMIT);
    $display("tb: errors");
    $finish;
  end

  initial begin
    logic [4:0] bits;
    in_ch.valid           <= 1'b0;
    in_ch.mode            <= KIND_SWITCH;
    in_ch.target_mode     <= MD_IDLE;
    in_ch.lease_ok        <= 1'b0;
    in_ch.transform_ok    <= 1'b0;
    in_ch.localization_ok <= 1'b0;
    in_ch.tilt_ok         <= 1'b0;
    in_ch.fence_ok        <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= CFG_LEASE;
    cfg_ch.data           <= 1'b0;
    rst_n                 <= 1'b0;
    cur_mode       = MD_IDLE;
    chk_on         = 5'b11111;
    send_idle_pct  = 14;
    recv_stall_pct = 62;
    n_requests     = 0;
    n_results      = 0;
    n_errs         = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIR_ROWS[i]) issue_request(DIR_ROWS[i].rq, DIR_ROWS[i].typed, DIR_ROWS[i].res);
    in_ch.valid <= 1'b0;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // reconfigure only once the block has drained
      while (mode_results_q.size() != 0) @(posedge clk);
      if (ph == 0) bits = 5'b11111;
      else if (ph == 1) bits = 5'b00000;
      else bits = 5'($urandom_range(0, 31));
      load_checks(bits, ph < 2);
      case (ph / 2)
        0: begin send_idle_pct = 14; recv_stall_pct = 62; end
        1: begin send_idle_pct = 62; recv_stall_pct = 14; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int goal = n_requests + PHASE_ITEMS; n_requests < goal; )
        issue_request(draw_request(), 1'b0, '0);
      in_ch.valid <= 1'b0;
    end

    while (mode_results_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("tb: %0d requests (directed and random) over %0d guard-check settings",
             n_requests, N_PHASES);
    $display("tb: %0d results compared, %0d mismatches", n_results, n_errs);
    if (n_errs == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rmsf_pkg.sv
rtl/rmsf_ifs.sv
rtl/robot_mode_safety_fsm_core.sv
rtl/rmsf_checker.sv
tb/tb.sv
